### hdl/sine_gaussian_burst_generator_macros.svh
// Assertion helpers used by the checker file.
// Both sample on clk and are switched off while rst_n is low.
`ifndef SINE_GAUSSIAN_BURST_GENERATOR_MACROS_SVH
`define SINE_GAUSSIAN_BURST_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sgb_pkg.sv
package sgb_pkg;

  localparam int IDX_W = 13;
  localparam int VAL_W = 16;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_FREQ_STEP    = 2'd0;
  localparam logic [1:0] REG_INV_WIDTH    = 2'd1;
  localparam logic [1:0] REG_START_OFFSET = 2'd2;

  localparam logic [31:0] FREQ_STEP_RST    = 32'd52428800;
  localparam logic [24:0] INV_WIDTH_RST    = 25'd204800;
  localparam logic [6:0]  START_OFFSET_RST = 7'd0;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Pipeline map. Envelope terms take a multiply stage and a divide stage each,
  // and so do the carrier terms, offset by one stage so they interleave.
  localparam int ENV_TERMS  = 12;
  localparam int SIN_TERMS  = 6;
  localparam int ST_PROD    = 1;
  localparam int ST_FOLD    = 2;
  localparam int ST_ANG     = 3;
  localparam int ST_A2      = 4;
  localparam int ENV_MUL0   = 4;
  localparam int SIN_MUL0   = 5;
  localparam int ST_SIN     = SIN_MUL0 + 2 * SIN_TERMS;
  localparam int ENV_SQ0    = ENV_MUL0 + 2 * ENV_TERMS;
  localparam int ENV_SQS    = 4;
  localparam int ST_MAG     = ENV_SQ0 + ENV_SQS;
  localparam int ST_OUT     = ST_MAG + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Exact truncating division of a 30-bit value by 12..1: (n * RCP) >> SHF.
  localparam logic [30:0] ENV_RCP [ENV_TERMS] = '{
    31'(((64'd1 << 34) / 12) + 1), 31'(((64'd1 << 34) / 11) + 1),
    31'(((64'd1 << 34) / 10) + 1), 31'(((64'd1 << 34) / 9) + 1),
    31'(((64'd1 << 33) / 8) + 1),  31'(((64'd1 << 33) / 7) + 1),
    31'(((64'd1 << 33) / 6) + 1),  31'(((64'd1 << 33) / 5) + 1),
    31'(((64'd1 << 32) / 4) + 1),  31'(((64'd1 << 32) / 3) + 1),
    31'(((64'd1 << 31) / 2) + 1),  31'(((64'd1 << 30) / 1) + 1)
  };
  localparam int ENV_SHF [ENV_TERMS] = '{34, 34, 34, 34, 33, 33, 33, 33, 32, 32, 31, 30};

  // Exact truncating division of a 32-bit value by the sine series divisors.
  localparam logic [32:0] SIN_RCP [SIN_TERMS] = '{
    33'(((64'd1 << 40) / 156) + 1), 33'(((64'd1 << 39) / 110) + 1),
    33'(((64'd1 << 39) / 72) + 1),  33'(((64'd1 << 38) / 42) + 1),
    33'(((64'd1 << 37) / 20) + 1),  33'(((64'd1 << 35) / 6) + 1)
  };
  localparam int SIN_SHF [SIN_TERMS] = '{40, 39, 39, 38, 37, 35};

endpackage

### hdl/sgb_ifs.sv
interface sgb_in_if
  import sgb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface sgb_out_if
  import sgb_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

### hdl/sine_gaussian_burst_generator.sv
// Sine-Gaussian burst generator.
// The in_ch channel takes one sample index per item; the out_ch channel returns
// one signed Q1.15 sample per item, in the order the indexes arrived. The
// sample is a Gaussian envelope times a sine carrier, both centered on the
// middle of the window shifted by start_offset.
// The work runs through a fixed pipeline of 34 register stages: one item can
// enter every clock cycle while out_ch is not stalled. The depth comes from
// the twelve envelope series terms, each one multiply stage and one
// reciprocal-divide stage, followed by four squaring stages and the final
// scale and round.
// When the receiver holds out_ch.ready low with a result waiting, the whole
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated.
// The registers freq_step, inv_width and start_offset sit on an APB port at
// byte addresses 0, 4 and 8; they must be written only while the block is idle,
// which the block itself does not enforce. Reset (rst_n low, synchronous)
// empties the pipeline and loads the register defaults.
module sine_gaussian_burst_generator
  import sgb_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  sgb_in_if.sink             in_ch,
  sgb_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  // The offset must cover minus half a window up to the largest index minus
  // half a window plus the largest shift.
  localparam int OFF_W = ($clog2(WINDOW_SAMPLES) + 1 > 15) ? $clog2(WINDOW_SAMPLES) + 1 : 15;
  localparam int X_W   = OFF_W + 25;
  localparam logic [OFF_W-1:0] HALF_WIN = OFF_W'(WINDOW_SAMPLES / 2);

  // Everything an item carries down the pipeline. Fields are filled in as the
  // stages reach them and then ride along unchanged.
  typedef struct packed {
    logic signed [OFF_W-1:0] off;
    logic [OFF_W-1:0]        absoff;
    logic [X_W-1:0]          x;
    logic [31:0]             phase;
    logic                    env_zero;
    logic                    neg;
    logic [23:0]             y;
    logic [30:0]             u;
    logic [30:0]             a;
    logic [31:0]             a2;
    logic [30:0]             e;
    logic [29:0]             pe;
    logic [30:0]             h;
    logic [31:0]             ph;
    logic [30:0]             s;
    logic [61:0]             prod;
    logic [VAL_W-1:0]        val;
  } pipe_t;

  logic [31:0] freq_step_r;
  logic [24:0] inv_width_r;
  logic [6:0]  start_offset_r;

  pipe_t                  st_r   [NUM_STAGES];
  pipe_t                  st_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0]  vld_r;
  logic                   adv;
  logic                   cfg_wr;

  // The pipeline moves as one: it advances whenever the last stage is empty
  // or its result is being taken.
  assign adv          = !vld_r[NUM_STAGES-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[NUM_STAGES-1];
  assign out_ch.sample_value = st_r[NUM_STAGES-1].val;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_step_r    <= FREQ_STEP_RST;
      inv_width_r    <= INV_WIDTH_RST;
      start_offset_r <= START_OFFSET_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FREQ_STEP:    freq_step_r    <= cfg_pwdata;
        REG_INV_WIDTH:    inv_width_r    <= cfg_pwdata[24:0];
        REG_START_OFFSET: start_offset_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FREQ_STEP:    cfg_prdata = freq_step_r;
      REG_INV_WIDTH:    cfg_prdata = {7'd0, inv_width_r};
      REG_START_OFFSET: cfg_prdata = {25'd0, start_offset_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Stage 0: signed offset of the sample from the burst center, and its size.
  always_comb begin
    logic [OFF_W-1:0] sum;
    sum = OFF_W'(in_ch.sample_index) - HALF_WIN + OFF_W'(start_offset_r);
    st_nxt[0]        = '0;
    st_nxt[0].off    = sum;
    st_nxt[0].absoff = sum[OFF_W-1] ? (~sum + 1'b1) : sum;
  end

  for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stg
    localparam bit ENV_MUL = (g >= ENV_MUL0) && (g < ENV_SQ0) && ((g - ENV_MUL0) % 2 == 0);
    localparam bit ENV_DIV = (g >= ENV_MUL0) && (g < ENV_SQ0) && ((g - ENV_MUL0) % 2 == 1);
    localparam bit SIN_MUL = (g >= SIN_MUL0) && (g < ST_SIN) && ((g - SIN_MUL0) % 2 == 0);
    localparam bit SIN_DIV = (g >= SIN_MUL0) && (g < ST_SIN) && ((g - SIN_MUL0) % 2 == 1);
    localparam int EJ = ENV_DIV ? (g - ENV_MUL0) / 2 : 0;
    localparam int SJ = SIN_DIV ? (g - SIN_MUL0) / 2 : 0;

    always_comb begin
      pipe_t       d;
      logic [31:0] off32;
      logic [65:0] mul_a;
      logic [65:0] mul_b;
      logic [62:0] rnd;
      logic [17:0] mag;
      logic [15:0] sat;
      d     = st_r[g-1];
      off32 = {{(32 - OFF_W){d.off[OFF_W-1]}}, d.off};
      mul_a = '0;
      mul_b = '0;
      rnd   = '0;
      mag   = '0;
      sat   = '0;
      st_nxt[g] = d;

      // Envelope argument and carrier phase; the phase wraps at one cycle.
      if (g == ST_PROD) begin
        mul_a = 66'(d.absoff) * 66'(inv_width_r);
        st_nxt[g].x = mul_a[X_W-1:0];
        mul_b = 66'(off32) * 66'(freq_step_r);
        st_nxt[g].phase = mul_b[31:0];
      end

      // Quadrant fold: odd quadrants mirror the angle, the lower half negates.
      if (g == ST_FOLD) begin
        st_nxt[g].env_zero = |d.x[X_W-1:26];
        st_nxt[g].neg      = d.phase[31];
        st_nxt[g].u        = d.phase[30] ? (Q30_ONE - {1'b0, d.phase[29:0]})
                                         : {1'b0, d.phase[29:0]};
      end

      if (g == ST_ANG) begin
        mul_a = 66'(d.x[25:0]) * 66'(d.x[25:0]);
        st_nxt[g].y = mul_a[51:28];
        mul_b = 66'(d.u) * 66'(HALF_PI_Q30);
        st_nxt[g].a = mul_b[60:30];
        st_nxt[g].e = Q30_ONE;
        st_nxt[g].h = Q30_ONE;
      end

      if (g == ST_A2) begin
        mul_a = 66'(d.a) * 66'(d.a);
        st_nxt[g].a2 = mul_a[61:30];
      end

      // Envelope series, one Horner term per stage pair.
      if (ENV_MUL) begin
        mul_b = 66'(d.y) * 66'(d.e);
        st_nxt[g].pe = mul_b[53:24];
      end
      if (ENV_DIV) begin
        mul_b = 66'(d.pe) * 66'(ENV_RCP[EJ]);
        st_nxt[g].e = Q30_ONE - 31'(mul_b >> ENV_SHF[EJ]);
      end

      // Sine series, one Horner term per stage pair.
      if (SIN_MUL) begin
        mul_a = 66'(d.a2) * 66'(d.h);
        st_nxt[g].ph = mul_a[61:30];
      end
      if (SIN_DIV) begin
        mul_a = 66'(d.ph) * 66'(SIN_RCP[SJ]);
        st_nxt[g].h = Q30_ONE - 31'(mul_a >> SIN_SHF[SJ]);
      end

      if (g == ST_SIN) begin
        mul_a = 66'(d.a) * 66'(d.h);
        st_nxt[g].s = mul_a[60:30];
      end

      // The series ran on x/4; four squarings bring it back to exp(-x^2).
      if ((g >= ENV_SQ0) && (g < ST_MAG)) begin
        mul_b = 66'(d.e) * 66'(d.e);
        st_nxt[g].e = mul_b[60:30];
      end

      if (g == ST_MAG) begin
        mul_a = 66'(d.env_zero ? 31'd0 : d.e) * 66'(d.s);
        st_nxt[g].prod = mul_a[61:0];
      end

      // Round half away from zero on the magnitude, saturate, then sign.
      if (g == ST_OUT) begin
        rnd = 63'(d.prod) + (63'd1 << 44);
        mag = rnd[62:45];
        sat = (mag > 18'd32767) ? 16'd32767 : {1'b0, mag[14:0]};
        st_nxt[g].val = d.neg ? (16'd0 - sat) : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

### hdl/sgb_checker.sv
`include "sine_gaussian_burst_generator_macros.svh"

module sgb_checker
  import sgb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VAL_W-1:0]  out_value,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata
);

  // A stalled result stays put.
  `SGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "result changed while stalled")

  // Saturation keeps the most negative code out.
  `SGB_ASSERT_NOW(a_no_min_code, out_valid, out_value != 16'h8000, "sample is -32768")

  // The pipeline takes an item whenever its output side can move.
  `SGB_ASSERT_NOW(a_ready_when_free, out_ready || !out_valid, in_ready, "input stalled with output free")

  // A frequency-step write reads back on the next cycle.
  `SGB_ASSERT_NOW(a_cfg_readback, $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite) && $past(cfg_paddr[3:2]) == REG_FREQ_STEP && cfg_paddr[3:2] == REG_FREQ_STEP && !(cfg_psel && cfg_penable && cfg_pwrite), cfg_prdata == $past(cfg_pwdata), "register readback mismatch")

endmodule

bind sine_gaussian_burst_generator sgb_checker u_sgb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.sample_value),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

### verif/sgb_tb_ifs.sv
`timescale 1ns / 1ps

// The block's own interfaces are used directly; this file only holds the
// payload record shared by the testbench.
package sgb_tb_pkg;
  import sgb_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
  } burst_sample_t;
endpackage

### verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the sine-Gaussian burst generator.
// A behavioral predictor computes each burst sample with the same fixed-point
// envelope and carrier series as the block. Every accepted sample index queues
// one expected sample; every accepted result is compared against the oldest
// expectation. Register settings move through defaults, extremes and random
// values, written over the APB port only while the pipeline is empty.
module testbench;
  import sgb_pkg::*;
  import sgb_tb_pkg::*;

  localparam int WINDOW = 8192;
  localparam int PIPE_DEPTH = 40;

  logic clk;
  logic rst_n;

  sgb_in_if in_ch ();
  sgb_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sine_gaussian_burst_generator #(.WINDOW_SAMPLES(WINDOW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the block's registers, used by the predictor.
  logic [31:0] freq_step_q;
  logic [24:0] inv_width_q;
  logic [6:0]  start_offset_q;

  burst_sample_t expected_samples[$];
  int error_count;
  int results_seen;
  bit sink_holdoff;   // forces a long receiver stall when set
  int sink_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Horner evaluation of exp(-y) to twelfth order in Q30, then raised to the
  // sixteenth power by four squarings, since y holds x^2/16.
  function automatic logic [63:0] envelope_q30(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] e;
    y = (x * x) >> 28;
    e = 64'd1 << 30;
    for (int k = 12; k >= 1; k--) begin
      e = (64'd1 << 30) - (((y * e) >> 24) / k);
    end
    for (int i = 0; i < 4; i++) begin
      e = (e * e) >> 30;
    end
    return e;
  endfunction

  // Sine magnitude by quadrant folding and a thirteenth-order odd series in Q30.
  function automatic logic [63:0] carrier_mag_q30(logic [31:0] phase, output bit neg);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] h;
    int divs[6];
    divs = '{156, 110, 72, 42, 20, 6};
    t = {34'd0, phase[29:0]};
    u = phase[30] ? ((64'd1 << 30) - t) : t;
    a = (u * 64'd1686629713) >> 30;
    a2 = (a * a) >> 30;
    h = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      h = (64'd1 << 30) - (((a2 * h) >> 30) / divs[i]);
    end
    neg = phase[31];
    return (a * h) >> 30;
  endfunction

  function automatic burst_sample_t predict_sample(logic [IDX_W-1:0] idx);
    longint signed offset;
    logic [63:0] absoff;
    logic [63:0] x;
    logic [63:0] env;
    logic [63:0] s;
    logic [63:0] mag;
    logic [31:0] phase;
    bit neg;
    burst_sample_t r;
    offset = longint'(idx) - WINDOW / 2 + longint'(start_offset_q);
    absoff = (offset < 0) ? 64'(-offset) : 64'(offset);
    x = absoff * inv_width_q;
    env = (x >= (64'd1 << 26)) ? 64'd0 : envelope_q30(x);
    phase = 32'(64'(offset) * freq_step_q);
    s = carrier_mag_q30(phase, neg);
    mag = (env * s + (64'd1 << 44)) >> 45;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    r.sample_value = neg ? -16'(mag) : 16'(mag);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the edge closing the access
  // phase commits the register, so the shadow copy is updated there too.
  task automatic write_register(logic [1:0] reg_idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({reg_idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (reg_idx)
      REG_FREQ_STEP: begin
        freq_step_q = value;
      end
      REG_INV_WIDTH: begin
        inv_width_q = value[24:0];
      end
      REG_START_OFFSET: begin
        start_offset_q = value[6:0];
      end
      default: begin
      end
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [31:0] fs, logic [31:0] iw, logic [31:0] so);
    write_register(REG_FREQ_STEP, fs);
    write_register(REG_INV_WIDTH, iw);
    write_register(REG_START_OFFSET, so);
  endtask

  // Sends one sample index after a random gap. The expectation is queued at
  // the accepting edge, before the result can possibly appear. Valid stays
  // high after the handshake; the next item or a drain decides what follows.
  task automatic send_index(logic [IDX_W-1:0] idx, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      wait_cycles(gap);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    expected_samples.push_back(predict_sample(idx));
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    wait_cycles(4);
  endtask

  // Result checker: compare each accepted sample with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", out_ch.sample_value));
      end else begin
        burst_sample_t exp_s;
        exp_s = expected_samples.pop_front();
        if (out_ch.sample_value !== exp_s.sample_value) begin
          report_mismatch($sformatf("sample_value got %0d want %0d",
                                    out_ch.sample_value, exp_s.sample_value));
        end
      end
    end
  end

  // Receiver: random stalls per item, or one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_holdoff) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_holdoff = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid || sink_holdoff));
    end
  end

  task automatic test_defaults();
    send_index('0);
    send_index(13'h1FFF);
    send_index(13'd4096);
    send_index(13'd4095);
    send_index(13'd4097);
    send_index(13'h1555);
    send_index(13'h0AAA);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    // Zero width: the envelope stays at one everywhere; top frequency.
    write_settings(32'h8000_0000, 32'd0, 32'd127);
    send_index(13'd4096);
    send_index(13'd3969);
    send_index(13'h1FFF);
    send_index(13'd0);
    drain_pipeline();
    // Zero frequency gives a flat zero carrier; inverse width of 2^24.
    write_settings(32'd0, 32'h0100_0000, 32'd0);
    send_index(13'd4096);
    send_index(13'd4097);
    send_index(13'd4100);
    drain_pipeline();
    // Quarter-cycle steps land on the carrier peak, where saturation lives.
    write_settings(32'h4000_0000, 32'd1, 32'd1);
    send_index(13'd4096);
    send_index(13'd4094);
    send_index(13'd4093);
    send_index(13'd4097);
    drain_pipeline();
    // Excess register bits are dropped by the block.
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_index(13'd4100);
    send_index(13'd8);
    drain_pipeline();
  endtask

  task automatic test_backpressure();
    write_settings(32'd52428800, 32'd204800, 32'd5);
    sink_hold_cycles = 120;
    sink_holdoff = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_index(13'($urandom_range(3900, 4300)), 1'b1);
    end
    drain_pipeline();
  endtask

  task automatic test_random_bursts();
    logic [31:0] fs;
    logic [31:0] iw;
    for (int phase_n = 0; phase_n < 10; phase_n++) begin
      fs = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 - $urandom_range(0, 3)
                                         : $urandom_range(0, 32'h8000_0000);
      // Mostly narrow-ish envelopes so the burst lives inside the window.
      iw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 25'h100_0000)
                                         : $urandom_range(0, 25'h8_0000);
      drain_pipeline();
      write_settings(fs, iw, $urandom_range(0, 127));
      for (int i = 0; i < 110; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_index(13'($urandom()));
        end else begin
          send_index(13'($urandom_range(3800, 4400)));
        end
      end
      if (phase_n == 4) begin
        // Sender pauses until all expected samples have arrived.
        drain_pipeline();
      end
    end
    drain_pipeline();
  endtask

  initial begin
    rst_n = 1'b0;
    error_count = 0;
    results_seen = 0;
    sink_holdoff = 1'b0;
    sink_hold_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.sample_index = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    freq_step_q = FREQ_STEP_RST;
    inv_width_q = INV_WIDTH_RST;
    start_offset_q = START_OFFSET_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_bursts();
    wait_cycles(PIPE_DEPTH);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
